// File: hw/rtl/mt32_pkg.sv
// Package for the 32-bit Mersenne Twister generator.
// Constants, controller/datapath interface types, the tempering and twist functions.
// No dependencies.
package mt32_pkg;

  localparam int unsigned Words    = 624;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned ShiftOfs = 397;
  localparam int unsigned WrapOfs  = Words - ShiftOfs;

  localparam logic [IdxW-1:0] LastIdx  = IdxW'(Words - 1);
  localparam logic [IdxW-1:0] FullPos  = IdxW'(Words);
  localparam logic [IdxW-1:0] FarAdd   = IdxW'(ShiftOfs);
  localparam logic [IdxW-1:0] FarSub   = IdxW'(WrapOfs);

  localparam logic [31:0] Matrix    = 32'h9908_B0DF;
  localparam logic [31:0] InitMult  = 32'd1812433253;
  localparam logic [31:0] UpperMask = 32'h8000_0000;
  localparam logic [31:0] LowerMask = 32'h7FFF_FFFF;
  localparam logic [31:0] TemperB   = 32'h9D2C_5680;
  localparam logic [31:0] TemperC   = 32'hEFC6_0000;

  localparam logic OpSeed    = 1'b0;
  localparam logic OpExtract = 1'b1;

  typedef struct packed {
    logic seed_load;
    logic seed_step;
    logic tw_pre;
    logic tw_first;
    logic tw_step;
    logic rd_pos;
    logic emit_word;
    logic emit_zero;
  } mt32_cmd_t;

  typedef struct packed {
    logic seeded;
    logic pos_full;
    logic seed_last;
    logic tw_last;
  } mt32_status_t;

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TemperB);
    y = y ^ ((y << 15) & TemperC);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic logic [31:0] twist_word(input logic [31:0] cur, input logic [31:0] nxt,
                                             input logic [31:0] far);
    logic [31:0] x;
    logic [31:0] xa;
    x  = (cur & UpperMask) | (nxt & LowerMask);
    xa = x >> 1;
    if (x[0]) begin
      xa = xa ^ Matrix;
    end
    return far ^ xa;
  endfunction

endpackage

// File: hw/rtl/mt32_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module mt32_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: hw/rtl/mt32_datapath.sv
// Datapath: state store, seed recurrence, twist, read position and tempered output.
// Depends on mt32_pkg and mt32_ram.
module mt32_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [31:0]           seed_i,
  input  mt32_pkg::mt32_cmd_t   cmd_i,
  output mt32_pkg::mt32_status_t status_o,
  output logic [31:0]           random_word_o,
  output logic                  strobe_o
);
  import mt32_pkg::*;

  logic [IdxW-1:0] k_q, k_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic            seeded_q, seeded_d;
  logic [31:0]     prev_q, prev_d;
  logic [31:0]     cur_q, cur_d;
  logic [31:0]     word_q, word_d;
  logic            strobe_q, strobe_d;

  logic            we;
  logic [IdxW-1:0] waddr;
  logic [31:0]     wdata;
  logic [IdxW-1:0] raddr_a, raddr_b;
  logic [31:0]     rdata_a, rdata_b;

  logic [IdxW-1:0] k_iss;
  logic [IdxW-1:0] nxt_idx, far_idx;
  logic [31:0]     mix;
  logic [31:0]     seed_word;
  logic [31:0]     tw_word;

  mt32_ram #(
    .WIDTH(32),
    .DEPTH(Words)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  assign mix       = prev_q ^ (prev_q >> 30);
  assign seed_word = mix * InitMult + {{(32-IdxW){1'b0}}, k_q};
  assign tw_word   = twist_word(cur_q, rdata_a, rdata_b);

  assign k_iss   = cmd_i.tw_first ? k_q : k_q + IdxW'(1);
  assign nxt_idx = (k_iss >= LastIdx) ? '0 : k_iss + IdxW'(1);
  assign far_idx = (k_iss < FarSub) ? k_iss + FarAdd : k_iss - FarSub;

  always_comb begin
    we    = 1'b0;
    waddr = k_q;
    wdata = seed_word;
    if (cmd_i.seed_load) begin
      we    = 1'b1;
      waddr = '0;
      wdata = seed_i;
    end else if (cmd_i.seed_step) begin
      we    = 1'b1;
    end else if (cmd_i.tw_step) begin
      we    = 1'b1;
      wdata = tw_word;
    end
  end

  always_comb begin
    raddr_a = '0;
    raddr_b = far_idx;
    if (cmd_i.rd_pos) begin
      raddr_a = pos_q;
    end else if (cmd_i.tw_first || cmd_i.tw_step) begin
      raddr_a = nxt_idx;
    end
  end

  always_comb begin
    k_d      = k_q;
    pos_d    = pos_q;
    seeded_d = seeded_q;
    prev_d   = prev_q;
    cur_d    = cur_q;
    word_d   = word_q;
    strobe_d = 1'b0;
    if (cmd_i.seed_load) begin
      prev_d   = seed_i;
      k_d      = IdxW'(1);
      pos_d    = FullPos;
      seeded_d = 1'b1;
    end
    if (cmd_i.seed_step) begin
      prev_d = seed_word;
      k_d    = k_q + IdxW'(1);
    end
    if (cmd_i.tw_pre) begin
      k_d = '0;
    end
    if (cmd_i.tw_first) begin
      cur_d = rdata_a;
    end
    if (cmd_i.tw_step) begin
      cur_d = rdata_a;
      k_d   = k_q + IdxW'(1);
      if (k_q == LastIdx) begin
        pos_d = '0;
      end
    end
    if (cmd_i.emit_word) begin
      word_d   = temper(rdata_a);
      strobe_d = 1'b1;
      pos_d    = pos_q + IdxW'(1);
    end
    if (cmd_i.emit_zero) begin
      word_d   = '0;
      strobe_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      seeded_q <= 1'b0;
      strobe_q <= 1'b0;
      k_q      <= '0;
    end else begin
      pos_q    <= pos_d;
      seeded_q <= seeded_d;
      strobe_q <= strobe_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    cur_q  <= cur_d;
    word_q <= word_d;
  end

  assign status_o.seeded    = seeded_q;
  assign status_o.pos_full  = (pos_q >= FullPos);
  assign status_o.seed_last = (k_q == LastIdx);
  assign status_o.tw_last   = (k_q == LastIdx);

  assign random_word_o = word_q;
  assign strobe_o      = strobe_q;

endmodule

// File: hw/rtl/mt32_ctrl.sv
// Controller state machine: sequences seed fill, twist pass and extract.
// Depends on mt32_pkg.
module mt32_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   operation_i,
  input  mt32_pkg::mt32_status_t status_i,
  output mt32_pkg::mt32_cmd_t    cmd_o,
  output logic                   busy_o
);
  import mt32_pkg::*;

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StSeed    = 3'd1;
  localparam logic [2:0] StTwPre   = 3'd2;
  localparam logic [2:0] StTwFirst = 3'd3;
  localparam logic [2:0] StTwRun   = 3'd4;
  localparam logic [2:0] StRead    = 3'd5;
  localparam logic [2:0] StExt     = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          priority if (operation_i == OpSeed) begin
            cmd_o.seed_load = 1'b1;
            state_d         = StSeed;
          end else if (!status_i.seeded) begin
            cmd_o.emit_zero = 1'b1;
          end else if (status_i.pos_full) begin
            state_d = StTwPre;
          end else begin
            cmd_o.rd_pos = 1'b1;
            state_d      = StExt;
          end
        end
      end
      StSeed: begin
        cmd_o.seed_step = 1'b1;
        if (status_i.seed_last) begin
          state_d = StIdle;
        end
      end
      StTwPre: begin
        cmd_o.tw_pre = 1'b1;
        state_d      = StTwFirst;
      end
      StTwFirst: begin
        cmd_o.tw_first = 1'b1;
        state_d        = StTwRun;
      end
      StTwRun: begin
        cmd_o.tw_step = 1'b1;
        if (status_i.tw_last) begin
          state_d = StRead;
        end
      end
      StRead: begin
        cmd_o.rd_pos = 1'b1;
        state_d      = StExt;
      end
      StExt: begin
        cmd_o.emit_word = 1'b1;
        state_d         = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);

endmodule

// File: hw/rtl/mersenne_twister_32_top.sv
// MT19937 generator, 32-bit. Extract: RAM read registered, then tempered word and
// strobe; busy holds off a new extract until then. Unseeded extract returns zero
// in the cycle after accept. An extract with all 624 words used first runs the
// twist. Seed: busy while the state fills, no result. Results cannot be stalled.
// Reset (async, active low) clears read position, seeded flag, strobe, index, state.
// Depends on mt32_pkg, mt32_ctrl, mt32_datapath, mt32_ram.
module mersenne_twister_32_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [31:0] seed_i,
  output logic        strobe_o,
  output logic [31:0] random_word_o
);
  import mt32_pkg::*;

  mt32_cmd_t    cmd;
  mt32_status_t status;

  mt32_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .operation_i(operation_i),
    .status_i   (status),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  mt32_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_i       (seed_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .random_word_o(random_word_o),
    .strobe_o     (strobe_o)
  );

endmodule

// File: hw/rtl/mt32_checker.sv
// Port-level checker for mersenne_twister_32_top, with its bind statement.
// Depends on mersenne_twister_32_top.
module mt32_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        operation_i,
  input logic        strobe_o
);

  logic accept;
  assign accept = start_i && !busy_o;

  a_seed_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !operation_i |=> busy_o && !strobe_o)
    else $error("seed transfer did not hold busy");

  a_extract_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i |=> busy_o || strobe_o)
    else $error("extract transfer neither busy nor answered");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy_o)
    else $error("result strobe while busy");

  a_strobe_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(accept && operation_i) || $past(busy_o))
    else $error("result strobe without pending extract");

endmodule

bind mersenne_twister_32_top mt32_checker u_chk (.*);

// File: verif/testbench.sv
// Self-checking testbench for mersenne_twister_32_top (32-bit MT19937 generator).
// Drives seed and extract commands with random gaps and checks every word
// against an in-bench generator model. Depends on mt32_pkg and the RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StoreWords  = 624;
  localparam int unsigned FarOffset   = 397;
  localparam logic [31:0] SeedMult    = 32'd1812433253;
  localparam logic [31:0] TwistMatrix = 32'h9908_B0DF;
  localparam logic [31:0] TopBit      = 32'h8000_0000;
  localparam logic [31:0] LowBits     = 32'h7FFF_FFFF;
  localparam logic [31:0] TemperMaskB = 32'h9D2C_5680;
  localparam logic [31:0] TemperMaskC = 32'hEFC6_0000;
  localparam int unsigned RandomItems = 1650;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        start_i       = 1'b0;
  logic        operation_i   = 1'b0;
  logic [31:0] seed_i        = '0;
  logic        busy_o;
  logic        strobe_o;
  logic [31:0] random_word_o;
  bit          calm_run      = 1'b0;

  class mt_word_predictor;
    logic [31:0] store [StoreWords];
    int unsigned pos;
    bit          seeded;
    logic [31:0] pending_words [$];
    int unsigned mismatches;

    function new();
      pos        = 0;
      seeded     = 1'b0;
      mismatches = 0;
    endfunction

    function void note_transfer(logic op, logic [31:0] sd);
      logic [31:0] y;
      logic [31:0] x;
      logic [31:0] xa;
      int unsigned k;
      if (op == mt32_pkg::OpSeed) begin
        store[0] = sd;
        for (k = 1; k < StoreWords; k++) begin
          store[k] = SeedMult * (store[k-1] ^ (store[k-1] >> 30)) + 32'(k);
        end
        pos    = StoreWords;
        seeded = 1'b1;
        return;
      end
      if (!seeded) begin
        pending_words.push_back('0);
        return;
      end
      if (pos >= StoreWords) begin
        for (k = 0; k < StoreWords; k++) begin
          x  = (store[k] & TopBit) | (store[(k + 1) % StoreWords] & LowBits);
          xa = x >> 1;
          if (x[0]) begin
            xa = xa ^ TwistMatrix;
          end
          store[k] = store[(k + FarOffset) % StoreWords] ^ xa;
        end
        pos = 0;
      end
      y   = store[pos];
      pos = pos + 1;
      y   = y ^ (y >> 11);
      y   = y ^ ((y << 7) & TemperMaskB);
      y   = y ^ ((y << 15) & TemperMaskC);
      y   = y ^ (y >> 18);
      pending_words.push_back(y);
    endfunction

    function void check_word(logic [31:0] got);
      logic [31:0] want;
      if (pending_words.size() == 0) begin
        $error("random_word: no word outstanding, expected none, actual %08h", got);
        mismatches++;
        return;
      end
      want = pending_words.pop_front();
      if (got !== want) begin
        $error("random_word: expected %08h, actual %08h", want, got);
        mismatches++;
      end
    endfunction
  endclass

  mt_word_predictor board;

  mersenne_twister_32_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .operation_i  (operation_i),
    .seed_i       (seed_i),
    .strobe_o     (strobe_o),
    .random_word_o(random_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // one command transfer; called and returns at a rising edge
  task automatic send_item(input logic op, input logic [31:0] sd);
    int unsigned gap;
    gap = 0;
    while (!calm_run && $urandom_range(0, 99) < 14) begin
      gap++;
    end
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    operation_i <= op;
    seed_i      <= sd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_transfer(op, sd);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && strobe_o) begin
      board.check_word(random_word_o);
    end
  end

  initial begin
    int n;
    board = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // unseeded extracts read back zero
    send_item(mt32_pkg::OpExtract, 32'hFFFF_FFFF);
    send_item(mt32_pkg::OpExtract, 32'h0000_0000);
    send_item(mt32_pkg::OpSeed, 32'h0000_0000);
    repeat (3) send_item(mt32_pkg::OpExtract, $urandom());
    send_item(mt32_pkg::OpSeed, 32'hFFFF_FFFF);
    repeat (2) send_item(mt32_pkg::OpExtract, 32'hFFFF_FFFF);
    send_item(mt32_pkg::OpSeed, 32'd5489);
    repeat (3) send_item(mt32_pkg::OpExtract, $urandom());
    // back-to-back reseeds
    send_item(mt32_pkg::OpSeed, 32'h8000_0001);
    send_item(mt32_pkg::OpSeed, 32'h1234_5678);
    send_item(mt32_pkg::OpExtract, 32'h0000_0000);
    send_item(mt32_pkg::OpSeed, 32'h7FFF_FFFE);
    repeat (2) send_item(mt32_pkg::OpExtract, 32'hFFFF_FFFF);

    // long extract run crosses a second twist, then sparse reseeds
    for (n = 0; n < RandomItems; n++) begin
      calm_run = (n >= 100 && n < 400);
      if (n == 0 || (n >= 700 && $urandom_range(0, 39) == 0)) begin
        send_item(mt32_pkg::OpSeed, $urandom());
      end else begin
        send_item(mt32_pkg::OpExtract, $urandom());
      end
    end
    start_i <= 1'b0;

    while (board.pending_words.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("mersenne_twister_32_top verification clean");
    end else begin
      $display("mersenne_twister_32_top verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("mersenne_twister_32_top verification failed");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/mt32_pkg.sv
hw/rtl/mt32_ram.sv
hw/rtl/mt32_datapath.sv
hw/rtl/mt32_ctrl.sv
hw/rtl/mersenne_twister_32_top.sv
hw/rtl/mt32_checker.sv
verif/testbench.sv
